/* rtl/ebalu_pkg.sv */
// Package for the eight-bit ALU with flags: operation codes, flag positions,
// request and result types. No dependencies.
`default_nettype none

package ebalu_pkg;

    localparam int OP_W    = 6;
    localparam int BYTE_W  = 8;
    localparam int BIDX_W  = 3;
    localparam int WORD_W  = 16;
    localparam int FLAG_W  = 4;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 32;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [OP_W-1:0] OP_ADD    = 6'd0;
    localparam logic [OP_W-1:0] OP_ADC    = 6'd1;
    localparam logic [OP_W-1:0] OP_SUB    = 6'd2;
    localparam logic [OP_W-1:0] OP_SBC    = 6'd3;
    localparam logic [OP_W-1:0] OP_CP     = 6'd4;
    localparam logic [OP_W-1:0] OP_AND    = 6'd5;
    localparam logic [OP_W-1:0] OP_OR     = 6'd6;
    localparam logic [OP_W-1:0] OP_XOR    = 6'd7;
    localparam logic [OP_W-1:0] OP_INC    = 6'd8;
    localparam logic [OP_W-1:0] OP_DEC    = 6'd9;
    localparam logic [OP_W-1:0] OP_RLC    = 6'd10;
    localparam logic [OP_W-1:0] OP_RRC    = 6'd11;
    localparam logic [OP_W-1:0] OP_RL     = 6'd12;
    localparam logic [OP_W-1:0] OP_RR     = 6'd13;
    localparam logic [OP_W-1:0] OP_RLCA   = 6'd14;
    localparam logic [OP_W-1:0] OP_RRCA   = 6'd15;
    localparam logic [OP_W-1:0] OP_RLA    = 6'd16;
    localparam logic [OP_W-1:0] OP_RRA    = 6'd17;
    localparam logic [OP_W-1:0] OP_SLA    = 6'd18;
    localparam logic [OP_W-1:0] OP_SRA    = 6'd19;
    localparam logic [OP_W-1:0] OP_SRL    = 6'd20;
    localparam logic [OP_W-1:0] OP_SWAP   = 6'd21;
    localparam logic [OP_W-1:0] OP_BIT    = 6'd22;
    localparam logic [OP_W-1:0] OP_RES    = 6'd23;
    localparam logic [OP_W-1:0] OP_SET    = 6'd24;
    localparam logic [OP_W-1:0] OP_CPL    = 6'd25;
    localparam logic [OP_W-1:0] OP_CCF    = 6'd26;
    localparam logic [OP_W-1:0] OP_SCF    = 6'd27;
    localparam logic [OP_W-1:0] OP_DAA    = 6'd28;
    localparam logic [OP_W-1:0] OP_ADDHL  = 6'd29;
    localparam logic [OP_W-1:0] OP_ADDSP  = 6'd30;
    localparam logic [OP_W-1:0] OP_INC16  = 6'd31;
    localparam logic [OP_W-1:0] OP_DEC16  = 6'd32;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] operand;
        logic [BIDX_W-1:0] bit_index;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [FLAG_W-1:0] flags_in;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        logic [WORD_W-1:0] result_word;
        logic [FLAG_W-1:0] flags_out;
        logic              write_result;
    } res_t;

endpackage

`default_nettype wire

/* rtl/ebalu_core.sv */
// Combinational datapath of the eight-bit ALU: one request in, one result out.
// Depends on ebalu_pkg.
`default_nettype none

module ebalu_core
    import ebalu_pkg::*;
(
    input  req_t req,
    output res_t res
);

    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] v;
    logic [BYTE_W-1:0] x;
    logic [FLAG_W-1:0] fi;
    logic              cin;
    logic              t;
    logic [8:0]        sum9;
    logic [4:0]        nib5;
    logic [8:0]        diff9;
    logic [4:0]        nibd5;
    logic [BYTE_W-1:0] rot;
    logic              rot_c;
    logic [BYTE_W-1:0] adj;
    logic [BYTE_W-1:0] daa_r;
    logic              daa_c;
    logic [16:0]       sum17;
    logic [12:0]       sum13;
    logic [8:0]        sp_lo9;
    logic [4:0]        sp_nib5;
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] rb;
    logic [WORD_W-1:0] rw;
    logic [FLAG_W-1:0] fo;
    logic              wr;

    always_comb
    begin
        a   = req.acc;
        v   = req.operand;
        fi  = req.flags_in;
        cin = fi[FLAG_C];
        t   = ((req.op == OP_ADC) || (req.op == OP_SBC)) ? cin : 1'b0;

        sum9  = {1'b0, a} + {1'b0, v} + {8'b0, t};
        nib5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'b0, t};
        diff9 = {1'b0, a} - {1'b0, v} - {8'b0, t};
        nibd5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'b0, t};

        x = (req.op >= OP_RLCA) ? a : v;
        case (req.op)
            OP_RLC, OP_RLCA:
            begin
                rot   = {x[6:0], x[7]};
                rot_c = x[7];
            end
            OP_RRC, OP_RRCA:
            begin
                rot   = {x[0], x[7:1]};
                rot_c = x[0];
            end
            OP_RL, OP_RLA:
            begin
                rot   = {x[6:0], cin};
                rot_c = x[7];
            end
            default:
            begin
                rot   = {cin, x[7:1]};
                rot_c = x[0];
            end
        endcase

        adj   = 8'h00;
        daa_c = cin;
        if (fi[FLAG_N])
        begin
            if (fi[FLAG_H])
                adj[3:0] = 4'h6;
            if (cin)
                adj[7:4] = 4'h6;
            daa_r = a - adj;
        end
        else
        begin
            if (fi[FLAG_H] || (a[3:0] > 4'h9))
                adj[3:0] = 4'h6;
            if (cin || (a > 8'h99))
            begin
                adj[7:4] = 4'h6;
                daa_c    = 1'b1;
            end
            daa_r = a + adj;
        end

        sum17   = {1'b0, req.word_a} + {1'b0, req.word_b};
        sum13   = {1'b0, req.word_a[11:0]} + {1'b0, req.word_b[11:0]};
        sp_lo9  = {1'b0, req.word_a[7:0]} + {1'b0, v};
        sp_nib5 = {1'b0, req.word_a[3:0]} + {1'b0, v[3:0]};

        mask = 8'b1 << req.bit_index;

        rb = 8'h00;
        rw = 16'h0000;
        fo = fi;
        wr = 1'b1;

        case (req.op)
            OP_ADD, OP_ADC:
            begin
                rb = sum9[7:0];
                fo = {(sum9[7:0] == 8'h00), 1'b0, nib5[4], sum9[8]};
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                rb = diff9[7:0];
                fo = {(diff9[7:0] == 8'h00), 1'b1, nibd5[4], diff9[8]};
                wr = (req.op != OP_CP);
            end
            OP_AND:
            begin
                rb = a & v;
                fo = {((a & v) == 8'h00), 1'b0, 1'b1, 1'b0};
            end
            OP_OR:
            begin
                rb = a | v;
                fo = {((a | v) == 8'h00), 3'b000};
            end
            OP_XOR:
            begin
                rb = a ^ v;
                fo = {((a ^ v) == 8'h00), 3'b000};
            end
            OP_INC:
            begin
                rb = v + 8'd1;
                fo = {(v == 8'hFF), 1'b0, (v[3:0] == 4'hF), cin};
            end
            OP_DEC:
            begin
                rb = v - 8'd1;
                fo = {(v == 8'h01), 1'b1, (v[3:0] == 4'h0), cin};
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR:
            begin
                rb = rot;
                fo = {(rot == 8'h00), 2'b00, rot_c};
            end
            OP_RLCA, OP_RRCA, OP_RLA, OP_RRA:
            begin
                rb = rot;
                fo = {3'b000, rot_c};
            end
            OP_SLA:
            begin
                rb = {v[6:0], 1'b0};
                fo = {(v[6:0] == 7'h00), 2'b00, v[7]};
            end
            OP_SRA:
            begin
                rb = {v[7], v[7:1]};
                fo = {(v[7:1] == 7'h00 && !v[7]), 2'b00, v[0]};
            end
            OP_SRL:
            begin
                rb = {1'b0, v[7:1]};
                fo = {(v[7:1] == 7'h00), 2'b00, v[0]};
            end
            OP_SWAP:
            begin
                rb = {v[3:0], v[7:4]};
                fo = {(v == 8'h00), 3'b000};
            end
            OP_BIT:
            begin
                rb = v;
                fo = {((v & mask) == 8'h00), 1'b0, 1'b1, cin};
                wr = 1'b0;
            end
            OP_RES:
            begin
                rb = v & ~mask;
            end
            OP_SET:
            begin
                rb = v | mask;
            end
            OP_CPL:
            begin
                rb = ~a;
                fo = {fi[FLAG_Z], 1'b1, 1'b1, cin};
            end
            OP_CCF:
            begin
                rb = a;
                fo = {fi[FLAG_Z], 1'b0, 1'b0, !cin};
            end
            OP_SCF:
            begin
                rb = a;
                fo = {fi[FLAG_Z], 1'b0, 1'b0, 1'b1};
            end
            OP_DAA:
            begin
                rb = daa_r;
                fo = {(daa_r == 8'h00), fi[FLAG_N], 1'b0, daa_c};
            end
            OP_ADDHL:
            begin
                rw = sum17[15:0];
                fo = {fi[FLAG_Z], 1'b0, sum13[12], sum17[16]};
            end
            OP_ADDSP:
            begin
                rw = req.word_a + {{8{v[7]}}, v};
                fo = {2'b00, sp_nib5[4], sp_lo9[8]};
            end
            OP_INC16:
            begin
                rw = req.word_a + 16'd1;
            end
            OP_DEC16:
            begin
                rw = req.word_a - 16'd1;
            end
            default:
            begin
                wr = 1'b0;
            end
        endcase

        res.result_byte  = rb;
        res.result_word  = rw;
        res.flags_out    = fo;
        res.write_result = wr;
    end

endmodule

`default_nettype wire

/* rtl/eight_bit_alu_with_flags_top.sv */
// Top level of the eight-bit ALU with Z/N/H/C flags: stream ports, request
// register, result register. Depends on ebalu_pkg and ebalu_core.
`default_nettype none

// One ALU request per cycle goes in while the output side keeps draining, and
// one result per request comes out, in order. A request is registered in the
// request register on acceptance, worked out by the combinational datapath and
// held in the result register, which it leaves once the output is ready. The
// two registers act as a two-entry pipeline: a new request is taken each cycle
// the output keeps draining, and while a result waits the request stage still
// takes one more. Compare and bit test report write_result low, as do unused
// operation codes.
module eight_bit_alu_with_flags_top
    import ebalu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // acc, operand, bit_index, word_a, word_b, flags_in, zero pad
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // op
    input  wire logic [OP_W-1:0]     s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // result_byte, result_word, flags_out, zero pad
    output logic [M_DATA_W-1:0]      m_axis_tdata,
    // write_result
    output logic                     m_axis_tuser
);

    logic in_valid_reg;
    logic in_valid_next;
    req_t in_req_reg;
    logic out_valid_reg;
    logic out_valid_next;
    res_t out_res_reg;
    res_t alu_res;
    logic out_adv;
    logic in_acc;
    req_t s_req;

    assign s_req.op        = s_axis_tuser;
    assign s_req.acc       = s_axis_tdata[7:0];
    assign s_req.operand   = s_axis_tdata[15:8];
    assign s_req.bit_index = s_axis_tdata[18:16];
    assign s_req.word_a    = s_axis_tdata[34:19];
    assign s_req.word_b    = s_axis_tdata[50:35];
    assign s_req.flags_in  = s_axis_tdata[54:51];

    ebalu_core u_core
    (
        .req (in_req_reg),
        .res (alu_res)
    );

    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_adv)
            out_valid_next = in_valid_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payloads unless the stage advances
    always_ff @(posedge clk)
    begin
        if (in_acc)
            in_req_reg <= s_req;
        if (out_adv && in_valid_reg)
            out_res_reg <= alu_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_res_reg.flags_out, out_res_reg.result_word,
                            out_res_reg.result_byte};
    assign m_axis_tuser  = out_res_reg.write_result;

endmodule

`default_nettype wire

/* rtl/ebalu_checker.sv */
// Port-level checker for the eight-bit ALU top level, with its bind.
// Depends on ebalu_pkg and eight_bit_alu_with_flags_top.
`default_nettype none

module ebalu_checker
    import ebalu_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic [S_DATA_W-1:0] s_axis_tdata,
    input wire logic [OP_W-1:0]     s_axis_tuser,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [M_DATA_W-1:0] m_axis_tdata,
    input wire logic                m_axis_tuser
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request refused with empty result stage");

    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        $past(s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready)
            && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken with both stages full");

    a_reset_empty: assert property (@(posedge clk)
        $past(!rst_n) |-> !m_axis_tvalid)
        else $error("result present straight after reset");

endmodule

bind eight_bit_alu_with_flags_top ebalu_checker u_ebalu_checker (.*);

`default_nettype wire
